@@ sv/qpr_pkg.sv @@
// Shared types, widths and codes of the quaternion product and rotate unit.
package qpr_pkg;

  localparam int unsigned DATA_W  = 16;
  localparam int unsigned QUAT_N  = 4;
  localparam int unsigned PROD1_W = 2 * DATA_W;
  localparam int unsigned T_W     = PROD1_W + 2;
  localparam int unsigned PROD2_W = T_W + DATA_W;
  localparam int unsigned ACC_W   = PROD2_W + 2;

  // Component positions inside a quaternion array.
  localparam int unsigned IW = 0;
  localparam int unsigned IX = 1;
  localparam int unsigned IY = 2;
  localparam int unsigned IZ = 3;

  // Operation codes.
  localparam logic OP_PRODUCT = 1'b0;
  localparam logic OP_ROTATE  = 1'b1;

  typedef struct packed {
    logic                     opcode;
    logic signed [DATA_W-1:0] a_w;
    logic signed [DATA_W-1:0] a_x;
    logic signed [DATA_W-1:0] a_y;
    logic signed [DATA_W-1:0] a_z;
    logic signed [DATA_W-1:0] b_w;
    logic signed [DATA_W-1:0] b_x;
    logic signed [DATA_W-1:0] b_y;
    logic signed [DATA_W-1:0] b_z;
  } qpr_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] res_w;
    logic signed [DATA_W-1:0] res_x;
    logic signed [DATA_W-1:0] res_y;
    logic signed [DATA_W-1:0] res_z;
    logic                     saturated;
  } qpr_out_t;

endpackage

@@ sv/quaternion_product_and_rotate.sv @@
// An accepted input transaction passes the product, sum, product, sum and output registers.
// Throughput: one transaction per cycle while out_ready_i is high; a stalled stage holds its item.
// The two 16-product multiplier arrays sit in separate pipeline stages, stage 1 and stage 3.
// Reset (rst_ni low, asynchronous) clears all stage valid bits; data registers are not reset.
// The unit holds no state between transactions, so reset needs no clearing pass.
module quaternion_product_and_rotate #(
  parameter int unsigned FRAC_BITS = 14
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  qpr_pkg::qpr_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output qpr_pkg::qpr_out_t out_data_o
);
  import qpr_pkg::*;

  // Pipeline overview:
  //   stage 1: products a_i * b_j (b_w forced to zero for a rotation)
  //   stage 2: Hamilton sums t = a * b, which is the final product for opcode 0
  //   stage 3: products t_i * a_j
  //   stage 4: Hamilton sums r = t * conj(a), conjugate folded into the signs
  //   stage 5: rounding, saturation and result selection (output register)
  // Each stage advances when it is empty or when the stage after it advances,
  // so bubbles collapse and a stalled output never drops or repeats a transaction.

  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic en1, en2, en3, en4, en5;

  assign en5        = !v5_q || out_ready_i;
  assign en4        = !v4_q || en5;
  assign en3        = !v3_q || en4;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_ready_o = en1;
  assign out_valid_o = v5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
    end
  end

  // Operands of the first multiplier array.
  logic signed [DATA_W-1:0] a_in [QUAT_N];
  logic signed [DATA_W-1:0] b_in [QUAT_N];

  always_comb begin
    a_in[IW] = in_data_i.a_w;
    a_in[IX] = in_data_i.a_x;
    a_in[IY] = in_data_i.a_y;
    a_in[IZ] = in_data_i.a_z;
    b_in[IW] = (in_data_i.opcode == OP_ROTATE) ? '0 : in_data_i.b_w;
    b_in[IX] = in_data_i.b_x;
    b_in[IY] = in_data_i.b_y;
    b_in[IZ] = in_data_i.b_z;
  end

  // Side registers that carry the opcode, a and t alongside the arithmetic.
  logic                     op1_q, op2_q, op3_q, op4_q;
  logic signed [DATA_W-1:0] a1_q [QUAT_N];
  logic signed [DATA_W-1:0] a2_q [QUAT_N];
  logic signed [T_W-1:0]    t3_q [QUAT_N];
  logic signed [T_W-1:0]    t4_q [QUAT_N];

  logic signed [PROD1_W-1:0] prod1 [QUAT_N][QUAT_N];
  logic signed [T_W-1:0]     t2    [QUAT_N];
  logic signed [PROD2_W-1:0] prod2 [QUAT_N][QUAT_N];
  logic signed [ACC_W-1:0]   r4    [QUAT_N];

  always_ff @(posedge clk_i) begin
    if (en1) begin
      op1_q <= in_data_i.opcode;
      a1_q  <= a_in;
    end
    if (en2) begin
      op2_q <= op1_q;
      a2_q  <= a1_q;
    end
    if (en3) begin
      op3_q <= op2_q;
      t3_q  <= t2;
    end
    if (en4) begin
      op4_q <= op3_q;
      t4_q  <= t3_q;
    end
  end

  qpr_prod_array #(
    .AW(DATA_W),
    .BW(DATA_W)
  ) u_prod1 (
    .clk_i (clk_i),
    .en_i  (en1),
    .p_i   (a_in),
    .q_i   (b_in),
    .prod_o(prod1)
  );

  qpr_ham_sum #(
    .PW    (PROD1_W),
    .SW    (T_W),
    .CONJ_Q(1'b0)
  ) u_sum1 (
    .clk_i (clk_i),
    .en_i  (en2),
    .prod_i(prod1),
    .sum_o (t2)
  );

  qpr_prod_array #(
    .AW(T_W),
    .BW(DATA_W)
  ) u_prod2 (
    .clk_i (clk_i),
    .en_i  (en3),
    .p_i   (t2),
    .q_i   (a2_q),
    .prod_o(prod2)
  );

  qpr_ham_sum #(
    .PW    (PROD2_W),
    .SW    (ACC_W),
    .CONJ_Q(1'b1)
  ) u_sum2 (
    .clk_i (clk_i),
    .en_i  (en4),
    .prod_i(prod2),
    .sum_o (r4)
  );

  qpr_round #(
    .FRAC_BITS(FRAC_BITS)
  ) u_round (
    .clk_i(clk_i),
    .en_i (en5),
    .op_i (op4_q),
    .t_i  (t4_q),
    .r_i  (r4),
    .out_o(out_data_o)
  );

  // Assertions.

  logic [4:0] vvec;
  assign vvec = {v1_q, v2_q, v3_q, v4_q, v5_q};

  // The number of transactions in flight changes only by acceptances at the two ports.
  a_occupancy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> ($countones(vvec) == $past($countones(vvec))
              + $past(int'(in_valid_i && in_ready_o))
              - $past(int'(out_valid_o && out_ready_i))))
    else $error("pipeline occupancy does not match the port transactions");

  // A completely full pipeline behind a stalled output must refuse new input.
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && v2_q && v3_q && v4_q && v5_q && !out_ready_i) |-> !in_ready_o)
    else $error("input accepted while the whole pipeline is stalled");

  // A rotation always leaves a zero scalar part in the output register.
  a_rotate_w: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v4_q && en5 && op4_q == OP_ROTATE) |=> (out_data_o.res_w == '0))
    else $error("rotation produced a nonzero scalar part");

endmodule

@@ sv/qpr_prod_array.sv @@
// Registered array of all sixteen component products of two quaternions.
module qpr_prod_array #(
  parameter int unsigned AW = 16,
  parameter int unsigned BW = 16
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [AW-1:0] p_i [qpr_pkg::QUAT_N],
  input  logic signed [BW-1:0] q_i [qpr_pkg::QUAT_N],
  output logic signed [AW+BW-1:0] prod_o [qpr_pkg::QUAT_N][qpr_pkg::QUAT_N]
);
  import qpr_pkg::*;

  // Row i holds p[i] times every component of q.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < QUAT_N; i++) begin
        for (int j = 0; j < QUAT_N; j++) begin
          prod_o[i][j] <= p_i[i] * q_i[j];
        end
      end
    end
  end

endmodule

@@ sv/qpr_ham_sum.sv @@
// Registered Hamilton sums over a product array, optionally against the conjugate of q.
module qpr_ham_sum #(
  parameter int unsigned PW     = 32,
  parameter int unsigned SW     = 34,
  parameter bit          CONJ_Q = 1'b0
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [PW-1:0] prod_i [qpr_pkg::QUAT_N][qpr_pkg::QUAT_N],
  output logic signed [SW-1:0] sum_o [qpr_pkg::QUAT_N]
);
  import qpr_pkg::*;

  logic signed [SW-1:0] e   [QUAT_N][QUAT_N];
  logic signed [SW-1:0] sum_d [QUAT_N];

  always_comb begin
    for (int i = 0; i < QUAT_N; i++) begin
      for (int j = 0; j < QUAT_N; j++) begin
        e[i][j] = SW'(prod_i[i][j]);
      end
    end
    if (!CONJ_Q) begin
      sum_d[IW] = e[IW][IW] - e[IX][IX] - e[IY][IY] - e[IZ][IZ];
      sum_d[IX] = e[IW][IX] + e[IX][IW] + e[IY][IZ] - e[IZ][IY];
      sum_d[IY] = e[IW][IY] - e[IX][IZ] + e[IY][IW] + e[IZ][IX];
      sum_d[IZ] = e[IW][IZ] + e[IX][IY] - e[IY][IX] + e[IZ][IW];
    end else begin
      // The vector part of q is negated, which flips every term with j != w.
      sum_d[IW] = e[IW][IW] + e[IX][IX] + e[IY][IY] + e[IZ][IZ];
      sum_d[IX] = e[IX][IW] - e[IW][IX] - e[IY][IZ] + e[IZ][IY];
      sum_d[IY] = e[IY][IW] - e[IW][IY] + e[IX][IZ] - e[IZ][IX];
      sum_d[IZ] = e[IZ][IW] - e[IW][IZ] - e[IX][IY] + e[IY][IX];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_o <= sum_d;
    end
  end

endmodule

@@ sv/qpr_round.sv @@
// Round half-up, saturate and select the result; holds the output register.
module qpr_round #(
  parameter int unsigned FRAC_BITS = 14
) (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  logic                            op_i,
  input  logic signed [qpr_pkg::T_W-1:0]   t_i [qpr_pkg::QUAT_N],
  input  logic signed [qpr_pkg::ACC_W-1:0] r_i [qpr_pkg::QUAT_N],
  output qpr_pkg::qpr_out_t               out_o
);
  import qpr_pkg::*;

  localparam int unsigned RW = (2 * FRAC_BITS + 2 > ACC_W) ? 2 * FRAC_BITS + 2 : ACC_W;

  // Returns {saturated, value}.
  function automatic logic [DATA_W:0] finish(input logic signed [RW-1:0] v,
                                             input int unsigned s);
    logic signed [RW-1:0] half;
    logic signed [RW-1:0] rnd;
    logic                 ovf;
    half      = '0;
    half[s-1] = 1'b1;
    rnd       = (v + half) >>> s;
    ovf       = (rnd[RW-1:DATA_W-1] != '0) && (rnd[RW-1:DATA_W-1] != '1);
    if (ovf) begin
      finish = {1'b1, rnd[RW-1], {(DATA_W-1){!rnd[RW-1]}}};
    end else begin
      finish = {1'b0, rnd[DATA_W-1:0]};
    end
  endfunction

  logic [DATA_W:0] fp [QUAT_N];
  logic [DATA_W:0] fr [QUAT_N];
  qpr_out_t        out_d;

  always_comb begin
    for (int i = 0; i < QUAT_N; i++) begin
      fp[i] = finish(RW'(t_i[i]), FRAC_BITS);
      fr[i] = finish(RW'(r_i[i]), 2 * FRAC_BITS);
    end
    if (op_i == OP_ROTATE) begin
      out_d.res_w     = '0;
      out_d.res_x     = fr[IX][DATA_W-1:0];
      out_d.res_y     = fr[IY][DATA_W-1:0];
      out_d.res_z     = fr[IZ][DATA_W-1:0];
      out_d.saturated = fr[IX][DATA_W] | fr[IY][DATA_W] | fr[IZ][DATA_W];
    end else begin
      out_d.res_w     = fp[IW][DATA_W-1:0];
      out_d.res_x     = fp[IX][DATA_W-1:0];
      out_d.res_y     = fp[IY][DATA_W-1:0];
      out_d.res_z     = fp[IZ][DATA_W-1:0];
      out_d.saturated = fp[IW][DATA_W] | fp[IX][DATA_W] | fp[IY][DATA_W] | fp[IZ][DATA_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_o <= out_d;
    end
  end

endmodule

@@ tb/sv/quaternion_product_and_rotate_tb.sv @@
// Self-checking testbench for the quaternion product and vector rotation unit.
`timescale 1ns / 100ps

module quaternion_product_and_rotate_tb;
  import qpr_pkg::*;

  // The DUT is built with its default fraction width, and the predictor follows it.
  localparam int unsigned FRAC        = 14;
  localparam int          TOTAL_ITEMS = 1250;
  // The pipeline is five stages deep, so this settle time after the last result is ample.
  localparam int          SETTLE_CYCLES = 20;
  // The timeout is several times the slowest legal run, in which
  // every result waits out the receiver's sparse-ready mode.
  localparam int          TIMEOUT_NS  = 5_000_000;

  // These shape the random stimulus. Unit quaternions give well-behaved rotations.
  // The other kinds push the rounding and clipping logic.
  typedef enum logic [1:0] {STIM_FULL, STIM_SMALL, STIM_CORNER, STIM_UNIT} stim_kind_e;

  // These are the output-side back-pressure modes that the receiver cycles through.
  typedef enum logic [1:0] {RX_ALWAYS, RX_MOSTLY, RX_RARELY, RX_PERIODIC} rx_mode_e;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  qpr_in_t  in_data_i   = '0;
  logic     out_ready_i = 1'b0;
  logic     in_ready_o;
  logic     out_valid_o;
  qpr_out_t out_data_o;

  // Input transactions wait here until the driver presents them. A parallel flag marks an
  // item that may only go out once every earlier result has been checked.
  qpr_in_t  pending_items[$];
  bit       drain_before[$];
  // Predicted results, oldest first, one per accepted input transaction.
  qpr_out_t expected_results[$];

  logic     in_taken = 1'b0;
  int       burst_left = 8;
  int       gap_left = 0;
  rx_mode_e rx_mode = RX_ALWAYS;
  int       rx_mode_left = 0;
  int       rx_tick = 0;

  int       failures = 0;
  int       results_seen = 0;
  int       products_sent = 0;
  int       rotations_sent = 0;
  int       clipped_seen = 0;

  quaternion_product_and_rotate #(
    .FRAC_BITS  (FRAC)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // Reset is held low from the start and released on a falling edge, away from the sampling edge.
  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  // ---------------------------------------------------------------------------------------
  // The predictor uses exact integer arithmetic. A rotation term is at most about 2^49 in
  // magnitude, so 64-bit signed values never overflow.
  // ---------------------------------------------------------------------------------------

  // This is the Hamilton product r = p * q on full-precision components.
  function automatic void hamilton_mul(
    input  longint pw, px, py, pz, qw, qx, qy, qz,
    output longint rw, rx, ry, rz
  );
    rw = pw * qw - px * qx - py * qy - pz * qz;
    rx = pw * qx + px * qw + py * qz - pz * qy;
    ry = pw * qy - px * qz + py * qw + pz * qx;
    rz = pw * qz + px * qy - py * qx + pz * qw;
  endfunction

  // This drops `shift` fraction bits with round-half-up, which is floor(v + half LSB).
  // It then clips to 16 bits. The arithmetic shift of a signed value is the floor.
  function automatic logic [DATA_W-1:0] round_clip(
    input longint      v,
    input int unsigned shift,
    inout bit          clipped
  );
    longint r;
    r = (v + (longint'(1) <<< (shift - 1))) >>> shift;
    if (r > 32767) begin
      r = 32767;
      clipped = 1'b1;
    end else if (r < -32768) begin
      r = -32768;
      clipped = 1'b1;
    end
    return r[DATA_W-1:0];
  endfunction

  function automatic qpr_out_t predict_result(input qpr_in_t it);
    qpr_out_t res;
    longint   aw, ax, ay, az, bw, bx, by, bz;
    longint   tw, tx, ty, tz, rw, rx, ry, rz;
    bit       clipped;
    aw = longint'(signed'(it.a_w));
    ax = longint'(signed'(it.a_x));
    ay = longint'(signed'(it.a_y));
    az = longint'(signed'(it.a_z));
    bw = longint'(signed'(it.b_w));
    bx = longint'(signed'(it.b_x));
    by = longint'(signed'(it.b_y));
    bz = longint'(signed'(it.b_z));
    clipped = 1'b0;
    if (it.opcode == OP_PRODUCT) begin
      hamilton_mul(aw, ax, ay, az, bw, bx, by, bz, rw, rx, ry, rz);
      res.res_w = round_clip(rw, FRAC, clipped);
      res.res_x = round_clip(rx, FRAC, clipped);
      res.res_y = round_clip(ry, FRAC, clipped);
      res.res_z = round_clip(rz, FRAC, clipped);
    end else begin
      // The vector is rotated as a * (0, v) * conj(a). The scalar of b is ignored. The result
      // carries twice the fraction bits, and its scalar part is forced to zero.
      hamilton_mul(aw, ax, ay, az, longint'(0), bx, by, bz, tw, tx, ty, tz);
      hamilton_mul(tw, tx, ty, tz, aw, -ax, -ay, -az, rw, rx, ry, rz);
      res.res_w = '0;
      res.res_x = round_clip(rx, 2 * FRAC, clipped);
      res.res_y = round_clip(ry, 2 * FRAC, clipped);
      res.res_z = round_clip(rz, 2 * FRAC, clipped);
    end
    res.saturated = clipped;
    return res;
  endfunction

  // ---------------------------------------------------------------------------------------
  // These helpers build the stimulus.
  // ---------------------------------------------------------------------------------------

  function automatic qpr_in_t make_item(input logic op, input int aw, ax, ay, az,
                                        input int bw, bx, by, bz);
    qpr_in_t it;
    it.opcode = op;
    it.a_w = 16'(aw);
    it.a_x = 16'(ax);
    it.a_y = 16'(ay);
    it.a_z = 16'(az);
    it.b_w = 16'(bw);
    it.b_x = 16'(bx);
    it.b_y = 16'(by);
    it.b_z = 16'(bz);
    return it;
  endfunction

  function automatic logic [DATA_W-1:0] corner_value();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h8001;
      2: return 16'hFFFF;
      3: return 16'h0000;
      4: return 16'h0001;
      5: return 16'h4000;
      6: return 16'hC000;
      default: return 16'h7FFF;
    endcase
  endfunction

  function automatic qpr_in_t random_item();
    qpr_in_t           it;
    logic [DATA_W-1:0] f [8];
    real               q [4];
    real               mag;
    stim_kind_e        kind;
    int                pick;
    pick = $urandom_range(0, 9);
    if (pick < 3)      kind = STIM_FULL;
    else if (pick < 5) kind = STIM_SMALL;
    else if (pick < 7) kind = STIM_CORNER;
    else               kind = STIM_UNIT;
    for (int i = 0; i < 8; i++) begin
      case (kind)
        STIM_FULL:   f[i] = 16'($urandom);
        STIM_SMALL:  f[i] = 16'($urandom_range(0, 16384)) - 16'd8192;
        STIM_CORNER: f[i] = $urandom_range(0, 1) ? corner_value() : 16'($urandom);
        default:     f[i] = 16'($urandom_range(0, 32768)) - 16'd16384;
      endcase
    end
    // In this mode a is replaced by a normalized quaternion, scaled to 1.0 = 2^14.
    if (kind == STIM_UNIT) begin
      mag = 0.0;
      while (mag < 1.0e4) begin
        mag = 0.0;
        for (int j = 0; j < 4; j++) begin
          q[j] = real'(int'($urandom_range(0, 20000)) - 10000);
          mag += q[j] * q[j];
        end
      end
      mag = $sqrt(mag);
      for (int j = 0; j < 4; j++) f[j] = 16'($rtoi(q[j] / mag * 16384.0));
    end
    it.opcode = $urandom_range(0, 1) ? OP_ROTATE : OP_PRODUCT;
    it.a_w = f[0];
    it.a_x = f[1];
    it.a_y = f[2];
    it.a_z = f[3];
    it.b_w = f[4];
    it.b_x = f[5];
    it.b_y = f[6];
    it.b_z = f[7];
    return it;
  endfunction

  task automatic queue_item(input qpr_in_t it, input bit drain);
    pending_items.push_back(it);
    drain_before.push_back(drain);
  endtask

  task automatic report_failure(input string msg);
    failures++;
    if (failures <= 10) $display("%s", msg);
  endtask

  task automatic check_result(input qpr_out_t got);
    qpr_out_t want;
    results_seen++;
    if (expected_results.size() == 0) begin
      report_failure($sformatf("result %0d arrived with no transaction outstanding",
                               results_seen));
      return;
    end
    want = expected_results.pop_front();
    if (want.saturated) clipped_seen++;
    if (got.res_w !== want.res_w)
      report_failure($sformatf("result %0d res_w: expected %0d, got %0d",
                               results_seen, want.res_w, got.res_w));
    if (got.res_x !== want.res_x)
      report_failure($sformatf("result %0d res_x: expected %0d, got %0d",
                               results_seen, want.res_x, got.res_x));
    if (got.res_y !== want.res_y)
      report_failure($sformatf("result %0d res_y: expected %0d, got %0d",
                               results_seen, want.res_y, got.res_y));
    if (got.res_z !== want.res_z)
      report_failure($sformatf("result %0d res_z: expected %0d, got %0d",
                               results_seen, want.res_z, got.res_z));
    if (got.saturated !== want.saturated)
      report_failure($sformatf("result %0d saturated: expected %0b, got %0b",
                               results_seen, want.saturated, got.saturated));
  endtask

  // ---------------------------------------------------------------------------------------
  // Driver: the input side changes on the falling edge. It presents a new item only when
  // nothing is showing, or when the item showing was taken at the last rising edge, so
  // valid stays high and the payload stays put under back-pressure. Bursts of random
  // length alternate with random gaps, and about a quarter of the bursts run with no gap.
  // ---------------------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (pending_items.size() == 0 ||
          (drain_before[0] && expected_results.size() != 0)) begin
        in_valid_i <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else begin
        in_valid_i <= 1'b1;
        in_data_i  <= pending_items.pop_front();
        void'(drain_before.pop_front());
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
    end
  end

  // The receiver has its own back-pressure. It switches at random among four modes:
  // always ready, mostly ready, rarely ready, or a fixed pattern that is ready five in eight.
  always @(negedge clk_i) begin
    if (rx_mode_left == 0) begin
      rx_mode      = rx_mode_e'($urandom_range(0, 3));
      rx_mode_left = $urandom_range(20, 150);
    end else begin
      rx_mode_left--;
    end
    rx_tick++;
    case (rx_mode)
      RX_ALWAYS: out_ready_i <= 1'b1;
      RX_MOSTLY: out_ready_i <= ($urandom_range(0, 3) != 0);
      RX_RARELY: out_ready_i <= ($urandom_range(0, 3) == 0);
      default:   out_ready_i <= ((rx_tick % 8) < 5);
    endcase
  end

  // Monitor: both channels are sampled on the rising edge. An accepted input transaction
  // queues its prediction. An accepted output transaction is checked against the oldest
  // one. A result can never come from an input accepted on the same edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) check_result(out_data_o);
      if (in_valid_i && in_ready_o) begin
        expected_results.push_back(predict_result(in_data_i));
        if (in_data_i.opcode == OP_PRODUCT) products_sent++;
        else rotations_sent++;
      end
    end
    in_taken <= rst_ni && in_valid_i && in_ready_o;
  end

  // ---------------------------------------------------------------------------------------
  // Stimulus and end of test.
  // ---------------------------------------------------------------------------------------
  initial begin
    // Products at zero and at the extremes, including the case where only the negative side
    // clips.
    queue_item(make_item(OP_PRODUCT, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0);
    queue_item(make_item(OP_PRODUCT, 32767, 32767, 32767, 32767,
                         32767, 32767, 32767, 32767), 1'b0);
    queue_item(make_item(OP_PRODUCT, -32768, -32768, -32768, -32768,
                         -32768, -32768, -32768, -32768), 1'b0);
    queue_item(make_item(OP_PRODUCT, 32767, -32768, 32767, -32768,
                         -32768, 32767, -32768, 32767), 1'b0);
    queue_item(make_item(OP_PRODUCT, -32768, 0, 0, 0, 32767, 0, 0, 0), 1'b0);
    // The identity on either side passes the other operand through.
    queue_item(make_item(OP_PRODUCT, 16384, 0, 0, 0, 1234, -5678, 32767, -32768), 1'b0);
    queue_item(make_item(OP_PRODUCT, -4321, 8765, -32768, 32767, 16384, 0, 0, 0), 1'b0);
    // Rounding at exactly half an LSB, just below it, half an LSB negative and just past that.
    queue_item(make_item(OP_PRODUCT, 1, 0, 0, 0, 8192, 0, 0, 0), 1'b0);
    queue_item(make_item(OP_PRODUCT, 1, 0, 0, 0, 8191, 0, 0, 0), 1'b0);
    queue_item(make_item(OP_PRODUCT, -1, 0, 0, 0, 8192, 0, 0, 0), 1'b0);
    queue_item(make_item(OP_PRODUCT, -1, 0, 0, 0, 8193, 0, 0, 0), 1'b0);
    // These check the basis products: i*j = k, j*i = -k and i*i = -1.
    queue_item(make_item(OP_PRODUCT, 0, 16384, 0, 0, 0, 0, 16384, 0), 1'b0);
    queue_item(make_item(OP_PRODUCT, 0, 0, 16384, 0, 0, 16384, 0, 0), 1'b0);
    queue_item(make_item(OP_PRODUCT, 0, 16384, 0, 0, 0, 16384, 0, 0), 1'b0);
    // The identity rotation leaves the vector alone, and the scalar of b must be ignored.
    queue_item(make_item(OP_ROTATE, 16384, 0, 0, 0, -1, 32767, -32768, 1), 1'b0);
    queue_item(make_item(OP_ROTATE, 16384, 0, 0, 0, 32767, 100, -200, 300), 1'b0);
    // A quarter turn about z and a half turn about x.
    queue_item(make_item(OP_ROTATE, 11585, 0, 0, 11585, 0, 16384, 0, 0), 1'b0);
    queue_item(make_item(OP_ROTATE, 0, 16384, 0, 0, 0, 1000, 2000, -3000), 1'b0);
    // A non-unit a scales the vector by |a|^2 and clips. A zero a gives a zero vector.
    queue_item(make_item(OP_ROTATE, 32767, 0, 0, 0, 0, 16384, -16384, 8192), 1'b0);
    queue_item(make_item(OP_ROTATE, 0, 0, 0, 0, -32768, 32767, -32768, 32767), 1'b0);
    queue_item(make_item(OP_ROTATE, -32768, -32768, -32768, -32768,
                         -32768, -32768, -32768, -32768), 1'b0);
    queue_item(make_item(OP_ROTATE, 32767, 32767, 32767, 32767,
                         32767, 32767, 32767, 32767), 1'b0);
    queue_item(make_item(OP_ROTATE, 1, -1, 1, -1, 0, 32767, -32768, 1), 1'b0);

    // In the random part the sender holds off twice until the pipeline is empty.
    for (int n = pending_items.size(); n < TOTAL_ITEMS; n++)
      queue_item(random_item(), (n == 23) || (n == 700));

    // First every item must be accepted, then every result must come back.
    while (pending_items.size() != 0 || in_valid_i) @(negedge clk_i);
    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);

    $display("Covered %0d products and %0d rotations. %0d results were checked.",
             products_sent, rotations_sent, results_seen);
    $display("%0d of the checked results were clipped, and %0d checks failed.",
             clipped_seen, failures);
    if (failures == 0 && expected_results.size() == 0) begin
      $display("PASS quaternion_product_and_rotate");
    end else begin
      $display("FAIL quaternion_product_and_rotate");
    end
    $finish;
  end

  // This watchdog catches a hung handshake or lost results.
  initial begin
    #(TIMEOUT_NS);
    $display("FAIL quaternion_product_and_rotate");
    $finish;
  end

endmodule
